>>> rtl/atpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_pkg
// Types, constants and the arctangent table shared by the tilt angle block.
// ----------------------------------------------------------------------------
package atpr_pkg;

  localparam int unsigned SAMPLES_DEF  = 50;   // calibration samples per run
  localparam int unsigned CNT_W        = 6;    // calibration sample counter
  localparam int unsigned ACC_W        = 16;   // raw accelerometer counts
  localparam int unsigned ANG_W        = 16;   // raw angle, 1/128 degree
  localparam int unsigned OFF_W        = 17;   // stored offsets
  localparam int unsigned OUT_W        = 18;   // delivered angles
  localparam int unsigned SUM_W        = 23;   // calibration sums
  localparam int unsigned CX_W         = 34;   // CORDIC x and y
  localparam int unsigned CZ_W         = 24;   // CORDIC angle, 2^-15 degree
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_IDX_W   = 4;
  localparam int unsigned SEQ_W        = 5;    // CORDIC step counter
  localparam int unsigned FRAC_SHIFT   = 14;   // input scaling ahead of CORDIC

  localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAL     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_PITCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ROLL  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ITER,
    S_ACC,
    S_DIV,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  capture;
    logic                  cordic_step;
    logic [STEP_IDX_W-1:0] step;
    logic                  acc;
    logic                  div_step;
    logic                  finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic not_ready;
    logic is_cal;
    logic cal_last;
  } sts_t;

  // atan(2^-i) in 2^-15 degree units, rounded to nearest.
  function automatic logic signed [CZ_W-1:0] atan_tab(input logic [STEP_IDX_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    case (i)
      4'd0:    v = 24'sd1474560;
      4'd1:    v = 24'sd870484;
      4'd2:    v = 24'sd459940;
      4'd3:    v = 24'sd233473;
      4'd4:    v = 24'sd117189;
      4'd5:    v = 24'sd58652;
      4'd6:    v = 24'sd29333;
      4'd7:    v = 24'sd14667;
      4'd8:    v = 24'sd7334;
      4'd9:    v = 24'sd3667;
      4'd10:   v = 24'sd1833;
      4'd11:   v = 24'sd917;
      4'd12:   v = 24'sd458;
      4'd13:   v = 24'sd229;
      4'd14:   v = 24'sd115;
      4'd15:   v = 24'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/atpr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_in_if
// Input channel: one accelerometer sample or offset load per transaction.
// ----------------------------------------------------------------------------
interface atpr_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [atpr_pkg::CMD_W-1:0]             cmd;
  logic                                   data_ready;
  logic signed [atpr_pkg::ACC_W-1:0]      accel_x;
  logic signed [atpr_pkg::ACC_W-1:0]      accel_y;
  logic signed [atpr_pkg::ACC_W-1:0]      accel_z;
  logic signed [atpr_pkg::OFF_W-1:0]      offset_pitch_in;
  logic signed [atpr_pkg::OFF_W-1:0]      offset_roll_in;

  modport source (
    output valid, cmd, data_ready, accel_x, accel_y, accel_z,
           offset_pitch_in, offset_roll_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_ready, accel_x, accel_y, accel_z,
           offset_pitch_in, offset_roll_in,
    output ready
  );
endinterface

>>> rtl/atpr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_out_if
// Result channel: status, pitch, roll and calibration flag per transaction.
// ----------------------------------------------------------------------------
interface atpr_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   status;
  logic signed [atpr_pkg::OUT_W-1:0]      pitch_out;
  logic signed [atpr_pkg::OUT_W-1:0]      roll_out;
  logic                                   calibration_done;

  modport source (
    output valid, status, pitch_out, roll_out, calibration_done,
    input  ready
  );
  modport sink (
    input  valid, status, pitch_out, roll_out, calibration_done,
    output ready
  );
endinterface

>>> rtl/atpr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_datapath
// Two CORDIC vectoring lanes, calibration sums, mean and offsets.
// ----------------------------------------------------------------------------
module atpr_datapath #(
  parameter int unsigned SAMPLES = atpr_pkg::SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  atpr_pkg::ctl_t                      ctl,
  output atpr_pkg::sts_t                      sts,
  input  logic [atpr_pkg::CMD_W-1:0]          in_cmd,
  input  logic                                in_data_ready,
  input  logic signed [atpr_pkg::ACC_W-1:0]   in_accel_x,
  input  logic signed [atpr_pkg::ACC_W-1:0]   in_accel_y,
  input  logic signed [atpr_pkg::ACC_W-1:0]   in_accel_z,
  input  logic signed [atpr_pkg::OFF_W-1:0]   in_offset_pitch_in,
  input  logic signed [atpr_pkg::OFF_W-1:0]   in_offset_roll_in,
  input  logic                                cfg_we,
  input  logic [atpr_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [atpr_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                out_status,
  output logic signed [atpr_pkg::OUT_W-1:0]   out_pitch_out,
  output logic signed [atpr_pkg::OUT_W-1:0]   out_roll_out,
  output logic                                out_calibration_done
);

  localparam int unsigned ACC_W  = atpr_pkg::ACC_W;
  localparam int unsigned OFF_W  = atpr_pkg::OFF_W;
  localparam int unsigned OUT_W  = atpr_pkg::OUT_W;
  localparam int unsigned SUM_W  = atpr_pkg::SUM_W;
  localparam int unsigned CX_W   = atpr_pkg::CX_W;
  localparam int unsigned CZ_W   = atpr_pkg::CZ_W;
  localparam int unsigned ANG_W  = atpr_pkg::ANG_W;
  localparam int unsigned CNT_W  = atpr_pkg::CNT_W;
  localparam int unsigned HALF   = SAMPLES / 2;
  localparam int unsigned DIV_SH = SUM_W + $clog2(SAMPLES);
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PRD_W  = SUM_W + RCP_W;
  // Reciprocal rounded up; the quotient is exact for every dividend below
  // 2^SUM_W because the rounding error stays under 2^-SUM_W.
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << DIV_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  // Captured transaction.
  logic [atpr_pkg::CMD_W-1:0]  cmd_r;
  logic                        rdy_r;
  logic signed [OFF_W-1:0]     offp_in_r, offr_in_r;
  logic                        zero_r [2];

  // CORDIC lanes: index 0 is pitch, index 1 is roll.
  logic signed [CX_W-1:0]      x_r [2], x_nxt [2];
  logic signed [CX_W-1:0]      y_r [2], y_nxt [2];
  logic signed [CZ_W-1:0]      z_r [2], z_nxt [2];
  logic signed [CX_W-1:0]      xs [2], ys [2];
  logic signed [CZ_W-1:0]      zr [2];
  logic signed [ANG_W-1:0]     ang [2];

  // Initial operands.
  logic signed [ACC_W:0]       ax17, ay17, az17;
  logic [ACC_W:0]              den;
  logic signed [ACC_W:0]       num [2];

  // Calibration state.
  logic signed [SUM_W-1:0]     sum_r [2], sum_new [2];
  logic [SUM_W-1:0]            mag [2];
  logic [CNT_W-1:0]            cnt_r;
  logic                        cal_done_r;
  logic signed [OFF_W-1:0]     off_r [2];
  logic signed [ACC_W-1:0]     tgt_r [2];

  // Mean by reciprocal multiplication.
  logic [SUM_W-1:0]            dvd_r [2];
  logic [SUM_W-1:0]            quo_r [2];
  logic                        neg_r [2];
  logic [PRD_W-1:0]            prod [2];
  logic signed [OFF_W-1:0]     mean [2], off_new [2];

  logic signed [OUT_W:0]       diff [2];

  assign ax17 = {in_accel_x[ACC_W-1], in_accel_x};
  assign ay17 = {in_accel_y[ACC_W-1], in_accel_y};
  assign az17 = {in_accel_z[ACC_W-1], in_accel_z};

  always_comb begin
    den    = in_accel_z[ACC_W-1] ? (ACC_W+1)'(-az17) : az17;
    num[0] = ay17;
    num[1] = in_accel_z[ACC_W-1] ? ax17 : -ax17;
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      xs[k] = x_r[k] >>> ctl.step;
      ys[k] = y_r[k] >>> ctl.step;
      if (!y_r[k][CX_W-1]) begin
        x_nxt[k] = x_r[k] + ys[k];
        y_nxt[k] = y_r[k] - xs[k];
        z_nxt[k] = z_r[k] + atpr_pkg::atan_tab(ctl.step);
      end else begin
        x_nxt[k] = x_r[k] - ys[k];
        y_nxt[k] = y_r[k] + xs[k];
        z_nxt[k] = z_r[k] - atpr_pkg::atan_tab(ctl.step);
      end
      // Round the 2^-15 degree sum to 1/128 degree.
      zr[k]  = z_r[k] + CZ_W'(128);
      ang[k] = zero_r[k] ? '0 : zr[k][CZ_W-1:8];

      sum_new[k] = sum_r[k] + SUM_W'(ang[k]);
      mag[k]     = sum_new[k][SUM_W-1] ? SUM_W'(-sum_new[k]) : SUM_W'(sum_new[k]);

      prod[k]    = PRD_W'(dvd_r[k]) * PRD_W'(RECIP);

      mean[k]    = neg_r[k] ? -OFF_W'(quo_r[k]) : OFF_W'(quo_r[k]);
      off_new[k] = mean[k] - OFF_W'(tgt_r[k]);

      diff[k]    = (OUT_W+1)'(ang[k]) - (OUT_W+1)'(off_r[k]);
    end
  end

  always_comb begin
    sts.is_load   = cmd_r == atpr_pkg::CMD_LOAD;
    sts.not_ready = (cmd_r != atpr_pkg::CMD_LOAD) && !rdy_r;
    sts.is_cal    = cmd_r == atpr_pkg::CMD_CAL;
    sts.cal_last  = (cmd_r == atpr_pkg::CMD_CAL)
                    && ((CNT_W+1)'(cnt_r) + (CNT_W+1)'(1) >= (CNT_W+1)'(SAMPLES));
  end

  // Capture, CORDIC and mean registers carry no reset.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r     <= in_cmd;
      rdy_r     <= in_data_ready;
      offp_in_r <= in_offset_pitch_in;
      offr_in_r <= in_offset_roll_in;
      for (int k = 0; k < 2; k++) begin
        zero_r[k] <= (num[k] == '0) && (den == '0);
        x_r[k]    <= CX_W'({den, atpr_pkg::FRAC_SHIFT'(0)});
        y_r[k]    <= {{(CX_W-ACC_W-1-atpr_pkg::FRAC_SHIFT){num[k][ACC_W]}},
                      num[k], atpr_pkg::FRAC_SHIFT'(0)};
        z_r[k]    <= '0;
      end
    end else if (ctl.cordic_step) begin
      for (int k = 0; k < 2; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
    end
    if (ctl.acc) begin
      for (int k = 0; k < 2; k++) begin
        dvd_r[k] <= mag[k] + SUM_W'(HALF);
        neg_r[k] <= sum_new[k][SUM_W-1];
      end
    end
    if (ctl.div_step) begin
      for (int k = 0; k < 2; k++) begin
        quo_r[k] <= SUM_W'(prod[k] >> DIV_SH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      if (sts.is_load) begin
        out_status           <= 1'b0;
        out_pitch_out        <= OUT_W'(offp_in_r);
        out_roll_out         <= OUT_W'(offr_in_r);
        out_calibration_done <= 1'b0;
      end else if (sts.not_ready) begin
        out_status           <= 1'b1;
        out_pitch_out        <= '0;
        out_roll_out         <= '0;
        out_calibration_done <= 1'b0;
      end else begin
        out_status           <= 1'b0;
        out_pitch_out        <= diff[0][OUT_W-1:0];
        out_roll_out         <= diff[1][OUT_W-1:0];
        out_calibration_done <= cal_done_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cal_done_r <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        sum_r[k] <= '0;
        off_r[k] <= '0;
        tgt_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          atpr_pkg::CFG_TARGET_PITCH: tgt_r[0] <= cfg_wdata;
          atpr_pkg::CFG_TARGET_ROLL:  tgt_r[1] <= cfg_wdata;
          default: ;
        endcase
      end
      if (ctl.capture) begin
        cal_done_r <= 1'b0;
      end
      // The sums and count clear on the sample that completes a run.
      if (ctl.acc) begin
        cal_done_r <= sts.cal_last;
        cnt_r      <= sts.cal_last ? '0 : cnt_r + CNT_W'(1);
        for (int k = 0; k < 2; k++) begin
          sum_r[k] <= sts.cal_last ? '0 : sum_new[k];
        end
      end
      if (ctl.finish) begin
        if (sts.is_load) begin
          off_r[0] <= offp_in_r;
          off_r[1] <= offr_in_r;
        end else if (!sts.not_ready && cal_done_r) begin
          off_r[0] <= off_new[0];
          off_r[1] <= off_new[1];
        end
      end
    end
  end

endmodule

>>> rtl/atpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atpr_ctrl
// Sequencer for capture, CORDIC steps, accumulation, mean and delivery.
// ----------------------------------------------------------------------------
module atpr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  atpr_pkg::sts_t  sts,
  output atpr_pkg::ctl_t  ctl
);

  localparam int unsigned SEQ_W = atpr_pkg::SEQ_W;

  atpr_pkg::state_t      state_r, state_nxt;
  logic [SEQ_W-1:0]      seq_r, seq_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atpr_pkg::S_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    ctl           = '0;
    ctl.step      = seq_r[atpr_pkg::STEP_IDX_W-1:0];
    case (state_r)
      atpr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = atpr_pkg::S_DECODE;
        end
      end
      atpr_pkg::S_DECODE: begin
        seq_nxt = '0;
        if (sts.is_load || sts.not_ready) begin
          state_nxt = atpr_pkg::S_FINISH;
        end else begin
          state_nxt = atpr_pkg::S_ITER;
        end
      end
      atpr_pkg::S_ITER: begin
        ctl.cordic_step = 1'b1;
        seq_nxt         = seq_r + SEQ_W'(1);
        if (seq_r == SEQ_W'(atpr_pkg::CORDIC_STEPS - 1)) begin
          seq_nxt   = '0;
          state_nxt = sts.is_cal ? atpr_pkg::S_ACC : atpr_pkg::S_FINISH;
        end
      end
      atpr_pkg::S_ACC: begin
        ctl.acc   = 1'b1;
        seq_nxt   = '0;
        state_nxt = sts.cal_last ? atpr_pkg::S_DIV : atpr_pkg::S_FINISH;
      end
      atpr_pkg::S_DIV: begin
        ctl.div_step = 1'b1;
        state_nxt    = atpr_pkg::S_FINISH;
      end
      atpr_pkg::S_FINISH: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          ctl.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = atpr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = atpr_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_busy_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == atpr_pkg::S_DECODE))
    else $error("capture did not start a sequence");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == atpr_pkg::S_FINISH))
    else $error("result presented outside the finish step");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == atpr_pkg::S_ITER) |-> (seq_r < SEQ_W'(atpr_pkg::CORDIC_STEPS)))
    else $error("CORDIC step count out of range");

  a_mean_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == atpr_pkg::S_DIV) |=> (state_r == atpr_pkg::S_FINISH))
    else $error("mean step did not hand over to delivery");

endmodule

>>> rtl/accel_tilt_pitch_roll.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll
// Pitch and roll in 1/128 degree from a three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Each input transaction on in_ch carries a command (measure, calibration
// sample or offset load), the data-ready flag, the three axis counts and the
// offsets used by a load. Each one yields exactly one result transaction on
// out_ch. The calibration targets are written through the cfg_ port; the user
// must write them while the block is idle, as the block does not enforce it.
// A measurement or calibration sample runs sixteen steps of a pair of CORDIC
// vectoring lanes, and a calibration sample then adds an accumulation step. The
// sample that completes a calibration run also passes through a step for the
// reciprocal multiplication that forms the mean. A load or a not-ready sample
// goes from decode straight to delivery. The next transaction is accepted in the
// cycle after the result is registered, so the block finishes each transaction
// before it takes the next one.
// Synchronous reset clears the offsets, sums, sample count and targets. When
// the receiver stalls, the result waits in the output register; the block
// takes the next transaction and holds its own result until the register is
// free.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll #(
  parameter int unsigned SAMPLES = atpr_pkg::SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  atpr_in_if.sink                          in_ch,
  atpr_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [atpr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [atpr_pkg::CFG_W-1:0]       cfg_wdata
);

  atpr_pkg::ctl_t ctl;
  atpr_pkg::sts_t sts;

  atpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  atpr_datapath #(
    .SAMPLES (SAMPLES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .sts                  (sts),
    .in_cmd               (in_ch.cmd),
    .in_data_ready        (in_ch.data_ready),
    .in_accel_x           (in_ch.accel_x),
    .in_accel_y           (in_ch.accel_y),
    .in_accel_z           (in_ch.accel_z),
    .in_offset_pitch_in   (in_ch.offset_pitch_in),
    .in_offset_roll_in    (in_ch.offset_roll_in),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata),
    .out_status           (out_ch.status),
    .out_pitch_out        (out_ch.pitch_out),
    .out_roll_out         (out_ch.roll_out),
    .out_calibration_done (out_ch.calibration_done)
  );

endmodule

>>> verif/accel_tilt_pitch_roll_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_tb
// Self-checking bench for the pitch and roll block.
// ----------------------------------------------------------------------------
// Samples and offset loads are pushed through the input channel while an
// in-bench model computes the CORDIC angles, the offset correction and the
// calibration mean. Each result transaction is compared with the oldest
// expected one. Directed corners come first, then calibration runs with
// random content and a random mix, under random gaps on both sides and
// calibration targets rewritten between phases.
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_tb;

  localparam int unsigned CMD_W     = atpr_pkg::CMD_W;
  localparam int unsigned ACC_W     = atpr_pkg::ACC_W;
  localparam int unsigned OFF_W     = atpr_pkg::OFF_W;
  localparam int unsigned OUT_W     = atpr_pkg::OUT_W;
  localparam int unsigned SUM_W     = atpr_pkg::SUM_W;
  localparam int unsigned CNT_W     = atpr_pkg::CNT_W;
  localparam int unsigned CFG_W     = atpr_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W = atpr_pkg::CFG_IDX_W;

  localparam int             N_CAL       = atpr_pkg::SAMPLES_DEF;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam longint         CYCLE_LIMIT = 1000000;
  localparam longint         ATAN_LUT [16] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57
  };

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic                    rdy;
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    logic signed [OFF_W-1:0] off_pitch;
    logic signed [OFF_W-1:0] off_roll;
  } sample_t;

  typedef struct {
    logic                    status;
    logic signed [OUT_W-1:0] pitch;
    logic signed [OUT_W-1:0] roll;
    logic                    done;
  } tilt_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  atpr_in_if  in_ch ();
  atpr_out_if out_ch ();

  accel_tilt_pitch_roll #(.SAMPLES(N_CAL)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Model state, mirroring the block's registers.
  logic signed [CFG_W-1:0] tgt_pitch, tgt_roll;
  logic signed [OFF_W-1:0] off_pitch, off_roll;
  logic signed [SUM_W-1:0] acc_pitch, acc_roll;
  logic [CNT_W-1:0]        cal_count;
  int unsigned             cal_runs;

  tilt_t       pending_tilts [$];
  int unsigned mismatch_count;
  bit          no_gaps;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // CORDIC vectoring, den >= 0, result in 1/128 degree.
  function automatic longint cordic_angle(input longint num, input longint den);
    longint cx, cy, cz, sx, sy;
    int     i;
    if (num == 0 && den == 0) return 0;
    cx = den * 16384;
    cy = num * 16384;
    cz = 0;
    for (i = 0; i < 16; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        cz = cz + ATAN_LUT[i];
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        cz = cz - ATAN_LUT[i];
      end
    end
    return (cz + 128) >>> 8;
  endfunction

  // Raw angles; a negative z folds the sample back into the upper half-plane.
  function automatic void tilt_angles(input longint ax, input longint ay, input longint az,
                                      output longint p, output longint r);
    if (az >= 0) begin
      p = cordic_angle(ay, az);
      r = cordic_angle(-ax, az);
    end else begin
      p = cordic_angle(ay, -az);
      r = cordic_angle(ax, -az);
    end
  endfunction

  // Rounded to nearest, ties away from zero.
  function automatic longint rounded_mean(input longint s);
    longint a, q;
    a = (s < 0) ? -s : s;
    q = (a + N_CAL / 2) / N_CAL;
    return (s < 0) ? -q : q;
  endfunction

  function automatic tilt_t predict_tilt(input sample_t s);
    tilt_t  t;
    longint p, r;
    t.status = 1'b0;
    t.pitch  = '0;
    t.roll   = '0;
    t.done   = 1'b0;
    if (s.cmd == atpr_pkg::CMD_LOAD) begin
      off_pitch = s.off_pitch;
      off_roll  = s.off_roll;
      t.pitch   = OUT_W'(longint'(off_pitch));
      t.roll    = OUT_W'(longint'(off_roll));
      return t;
    end
    if (!s.rdy) begin
      t.status = 1'b1;
      return t;
    end
    tilt_angles(s.ax, s.ay, s.az, p, r);
    t.pitch = OUT_W'(p - longint'(off_pitch));
    t.roll  = OUT_W'(r - longint'(off_roll));
    if (s.cmd == atpr_pkg::CMD_CAL) begin
      acc_pitch = SUM_W'(longint'(acc_pitch) + p);
      acc_roll  = SUM_W'(longint'(acc_roll) + r);
      cal_count = cal_count + 1'b1;
      if (cal_count >= N_CAL) begin
        off_pitch = OFF_W'(rounded_mean(acc_pitch) - longint'(tgt_pitch));
        off_roll  = OFF_W'(rounded_mean(acc_roll) - longint'(tgt_roll));
        acc_pitch = '0;
        acc_roll  = '0;
        cal_count = '0;
        t.done    = 1'b1;
        cal_runs++;
      end
    end
    return t;
  endfunction

  function automatic logic signed [ACC_W-1:0] rand_axis();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'sh7FFF;
    if (pick == 1) return 16'sh8000;
    if (pick == 2) return '0;
    if (pick < 7) return ACC_W'(int'($urandom_range(0, 400)) - 200);
    return ACC_W'($urandom);
  endfunction

  function automatic logic signed [OFF_W-1:0] rand_offset();
    case ($urandom_range(0, 19))
      0:       return OFF_W'(46080);
      1:       return OFF_W'(-46080);
      2:       return OFF_W'(-65536);
      3:       return OFF_W'(65535);
      4:       return '0;
      default: return OFF_W'($urandom);
    endcase
  endfunction

  function automatic sample_t make_sample(input logic [CMD_W-1:0] cmd, input logic rdy);
    sample_t s;
    s.cmd       = cmd;
    s.rdy       = rdy;
    s.ax        = rand_axis();
    s.ay        = rand_axis();
    s.az        = rand_axis();
    s.off_pitch = rand_offset();
    s.off_roll  = rand_offset();
    return s;
  endfunction

  function automatic bit lands_on_tie(input longint sum, input longint ang);
    longint a;
    a = ((sum + ang) < 0) ? -(sum + ang) : (sum + ang);
    return (a % N_CAL) == (N_CAL / 2);
  endfunction

  // Picks y, then x, so that both means of the closing sample sit exactly halfway.
  function automatic void force_tie(inout sample_t s);
    longint p, r;
    int     tries;
    if (s.az == 0) s.az = 16'sd1;
    for (tries = 0; tries < 20000; tries++) begin
      tilt_angles(s.ax, s.ay, s.az, p, r);
      if (lands_on_tie(acc_pitch, p)) break;
      s.ay = rand_axis();
    end
    for (tries = 0; tries < 20000; tries++) begin
      tilt_angles(s.ax, s.ay, s.az, p, r);
      if (lands_on_tie(acc_roll, r)) break;
      s.ax = rand_axis();
    end
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  task automatic send_sample(input sample_t s);
    while (!no_gaps && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= s.cmd;
    in_ch.data_ready      <= s.rdy;
    in_ch.accel_x         <= s.ax;
    in_ch.accel_y         <= s.ay;
    in_ch.accel_z         <= s.az;
    in_ch.offset_pitch_in <= s.off_pitch;
    in_ch.offset_roll_in  <= s.off_roll;
    do @(posedge clk); while (!in_ch.ready);
    pending_tilts.push_back(predict_tilt(s));
  endtask

  task automatic send_axes(input logic [CMD_W-1:0] cmd, input logic rdy,
                           input logic signed [ACC_W-1:0] x, input logic signed [ACC_W-1:0] y,
                           input logic signed [ACC_W-1:0] z);
    sample_t s;
    s    = make_sample(cmd, rdy);
    s.ax = x;
    s.ay = y;
    s.az = z;
    send_sample(s);
  endtask

  task automatic send_load(input logic signed [OFF_W-1:0] p, input logic signed [OFF_W-1:0] r,
                           input logic rdy);
    sample_t s;
    s           = make_sample(atpr_pkg::CMD_LOAD, rdy);
    s.off_pitch = p;
    s.off_roll  = r;
    send_sample(s);
  endtask

  // Every transaction yields a result, so an empty queue means the block is idle.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_tilts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_targets(input logic [CFG_W-1:0] p, input logic [CFG_W-1:0] r);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= atpr_pkg::CFG_TARGET_PITCH;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_idx   <= atpr_pkg::CFG_TARGET_ROLL;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tgt_pitch = p;
    tgt_roll  = r;
  endtask

  task automatic test_angle_corners();
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sd0, 16'sh7FFF, 16'sd0);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sd0, 16'sh8000, 16'sd0);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sh8000, 16'sd0, 16'sd0);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sh7FFF, 16'sd0, 16'sd5);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sd100, -16'sd200, -16'sd1);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sd1, 16'sd1, 16'sh7FFF);
    send_axes(CMD_SPARE, 1'b1, 16'sh7FFF, 16'sh8000, 16'sh8000);
  endtask

  task automatic test_not_ready();
    send_axes(atpr_pkg::CMD_MEASURE, 1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_axes(atpr_pkg::CMD_CAL, 1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    send_axes(CMD_SPARE, 1'b0, 16'sd3, 16'sd4, 16'sd5);
    send_load(OFF_W'(123), OFF_W'(-321), 1'b0);
  endtask

  task automatic test_offset_load();
    send_load(OFF_W'(46080), OFF_W'(-46080), 1'b1);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sd500, -16'sd700, 16'sd900);
    send_load(OFF_W'(-65536), OFF_W'(65535), 1'b1);
    send_axes(atpr_pkg::CMD_MEASURE, 1'b1, 16'sh8000, 16'sh7FFF, -16'sd900);
    // A calibration sample in progress must survive the following load.
    send_axes(atpr_pkg::CMD_CAL, 1'b1, -16'sd1234, 16'sd2345, 16'sd3456);
    send_load('0, '0, 1'b0);
  endtask

  task automatic run_calibration(input bit tie);
    sample_t     s;
    int unsigned start_runs, pick;
    start_runs = cal_runs;
    while (cal_runs == start_runs) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        s = make_sample(atpr_pkg::CMD_CAL, 1'b1);
        if (tie && cal_count == N_CAL - 1) force_tie(s);
      end else if (pick < 89) begin
        s = make_sample(atpr_pkg::CMD_MEASURE, 1'b1);
      end else if (pick < 94) begin
        s = make_sample(atpr_pkg::CMD_CAL, 1'b0);
      end else if (pick < 97) begin
        s = make_sample(CMD_SPARE, 1'($urandom_range(0, 1)));
      end else begin
        s = make_sample(atpr_pkg::CMD_LOAD, 1'($urandom_range(0, 1)));
      end
      send_sample(s);
    end
  endtask

  task automatic test_calibration_runs();
    write_targets(CFG_W'(23040), CFG_W'(-23040));
    run_calibration(1'b0);
    run_calibration(1'b1);
    write_targets(CFG_W'(-23040), CFG_W'(23040));
    run_calibration(1'b1);
    write_targets('0, '0);
    no_gaps = 1'b1;
    run_calibration(1'b0);
    run_calibration(1'b1);
    no_gaps = 1'b0;
    write_targets(CFG_W'($urandom), CFG_W'($urandom));
    run_calibration(1'b1);
    write_targets(16'h7FFF, 16'h8000);
    run_calibration(1'b0);
  endtask

  task automatic test_random_mix();
    sample_t     s;
    int unsigned pick;
    int          phase, n;
    for (phase = 0; phase < 4; phase++) begin
      write_targets(CFG_W'(int'($urandom_range(0, 46080)) - 23040),
                    CFG_W'(int'($urandom_range(0, 46080)) - 23040));
      no_gaps = (phase == 2);
      for (n = 0; n < 200; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      s = make_sample(atpr_pkg::CMD_MEASURE, 1'b1);
        else if (pick < 70) s = make_sample(atpr_pkg::CMD_CAL, 1'b1);
        else if (pick < 80) s = make_sample(CMD_SPARE, 1'($urandom_range(0, 1)));
        else if (pick < 88) s = make_sample(atpr_pkg::CMD_LOAD, 1'($urandom_range(0, 1)));
        else                s = make_sample(CMD_W'($urandom_range(0, 1)), 1'b0);
        send_sample(s);
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 36);
    end
  end

  always @(posedge clk) begin
    tilt_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_tilts.size() == 0) begin
        flag_error($sformatf("%0t: result transaction with nothing expected", $realtime));
      end else begin
        want = pending_tilts.pop_front();
        if (out_ch.status !== want.status || out_ch.pitch_out !== want.pitch ||
            out_ch.roll_out !== want.roll || out_ch.calibration_done !== want.done) begin
          flag_error($sformatf(
            "%0t: expected status %0b pitch %0d roll %0d done %0b, got %0b %0d %0d %0b",
            $realtime, want.status, want.pitch, want.roll, want.done, out_ch.status,
            out_ch.pitch_out, out_ch.roll_out, out_ch.calibration_done));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cycles         = 0;
    mismatch_count = 0;
    no_gaps        = 1'b0;
    tgt_pitch      = '0;
    tgt_roll       = '0;
    off_pitch      = '0;
    off_roll       = '0;
    acc_pitch      = '0;
    acc_roll       = '0;
    cal_count      = '0;
    cal_runs       = 0;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= atpr_pkg::CFG_TARGET_PITCH;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= atpr_pkg::CMD_MEASURE;
    in_ch.data_ready      <= 1'b0;
    in_ch.accel_x         <= '0;
    in_ch.accel_y         <= '0;
    in_ch.accel_z         <= '0;
    in_ch.offset_pitch_in <= '0;
    in_ch.offset_roll_in  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_angle_corners();
    test_not_ready();
    test_offset_load();
    test_calibration_runs();
    test_random_mix();

    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_tilts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
